// ----- rtl/w3cf_pkg.sv -----
// Shared types, field widths, register indexes and the per-channel 3x3 filter.
// Used by the filter top level and its port checker; depends on nothing.
package w3cf_pkg;

   localparam int CHAN_W         = 8;
   localparam int PIX_W          = 3 * CHAN_W;
   localparam int OUT_COL_W      = 10;
   localparam int OUT_ROW_W      = 12;
   localparam int REQ_TDATA_W    = 24;
   localparam int RSP_FIELDS_W   = OUT_COL_W + OUT_ROW_W + PIX_W;
   localparam int RSP_TDATA_W    = 48;
   localparam int RSP_PAD_W      = RSP_TDATA_W - RSP_FIELDS_W;

   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int MODE_W         = 2;
   localparam int GAIN_W         = 8;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_MODE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BOOST_GAIN   = 2'd3;

   localparam logic [MODE_W-1:0] MODE_LAPLACIAN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BOOST     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SOBEL     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_GAUSSIAN  = 2'd3;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;
   localparam logic [GAIN_W-1:0]         BOOST_GAIN_RST   = 8'd16;

   // One result transaction; rgb holds red in the low byte, blue in the high byte
   typedef struct packed {
      logic [PIX_W-1:0]     rgb;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
   } result_type;

   function automatic logic signed [19:0] sx8(input logic [CHAN_W-1:0] v);
      return signed'({12'd0, v});
   endfunction

   function automatic logic [CHAN_W-1:0] clip_u8(input logic signed [19:0] v);
      logic [CHAN_W-1:0] r;
      priority if (v < 20'sd0) begin
         r = '0;
      end else if (v > 20'sd255) begin
         r = 8'hFF;
      end else begin
         r = v[CHAN_W-1:0];
      end
      return r;
   endfunction

   // p<row><col>: row 0 top, col 0 left, one channel
   function automatic logic [CHAN_W-1:0] filter_channel(
      input logic [MODE_W-1:0] mode,
      input logic [GAIN_W-1:0] gain,
      input logic [CHAN_W-1:0] p00, input logic [CHAN_W-1:0] p01,
      input logic [CHAN_W-1:0] p02, input logic [CHAN_W-1:0] p10,
      input logic [CHAN_W-1:0] p11, input logic [CHAN_W-1:0] p12,
      input logic [CHAN_W-1:0] p20, input logic [CHAN_W-1:0] p21,
      input logic [CHAN_W-1:0] p22);
      logic signed [19:0] c;
      logic signed [19:0] edges;
      logic signed [19:0] corners;
      logic signed [19:0] boost;
      logic signed [19:0] gx;
      logic signed [19:0] gy;
      logic signed [19:0] gsum;
      logic [CHAN_W-1:0]  r;
      c       = sx8(p11);
      edges   = sx8(p01) + sx8(p10) + sx8(p12) + sx8(p21);
      corners = sx8(p00) + sx8(p02) + sx8(p20) + sx8(p22);
      boost   = ((20'sd8 * c - edges - corners) * 20'sd16) + sx8(gain) * c;
      gx      = (sx8(p02) + 20'sd2 * sx8(p12) + sx8(p22)) -
                (sx8(p00) + 20'sd2 * sx8(p10) + sx8(p20));
      gy      = (sx8(p20) + 20'sd2 * sx8(p21) + sx8(p22)) -
                (sx8(p00) + 20'sd2 * sx8(p01) + sx8(p02));
      gsum    = sx8(clip_u8(gx)) + sx8(clip_u8(gy));
      unique case (mode)
         MODE_LAPLACIAN: r = clip_u8(20'sd9 * c - edges - corners);
         // boost is non-negative when shifted, so the shift floors
         MODE_BOOST:     r = (boost < 20'sd0) ? '0 : clip_u8(boost >>> 4);
         MODE_SOBEL:     r = clip_u8(gsum);
         MODE_GAUSSIAN:  r = clip_u8((corners + 20'sd2 * edges + 20'sd4 * c) >>> 4);
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/w3cf_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered read data.
// Generic storage for the line buffers; no dependencies.
module w3cf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/window3x3_convolution_filter_top.sv -----
// 3x3 window convolution filter over a raster RGB pixel stream.
// A result is held in the compute-stage register and then the output register before
// it is presented; result-side back-pressure can hold it in either register.
// Throughput: one pixel per cycle while rsp_tready stays high; a pixel that completes
// an interior result and is itself on the border holds the input while its second leaves.
// Reset clears counters, window and handshake state; the line buffer RAMs are not
// cleared and fill as the first two rows arrive.
module window3x3_convolution_filter_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // tdata: in_red[7:0], in_green[15:8], in_blue[23:16]
   input  logic [w3cf_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata: out_col[9:0], out_row[21:10], out_red[29:22], out_green[37:30],
   //        out_blue[45:38], zero[47:46]
   output logic [w3cf_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [w3cf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [w3cf_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WCW  = ($clog2(MAX_WIDTH + 1) > w3cf_pkg::FRAME_WIDTH_W) ?
                         $clog2(MAX_WIDTH + 1) : w3cf_pkg::FRAME_WIDTH_W;
   localparam int HCW  = ($clog2(MAX_HEIGHT + 1) > w3cf_pkg::FRAME_HEIGHT_W) ?
                         $clog2(MAX_HEIGHT + 1) : w3cf_pkg::FRAME_HEIGHT_W;
   localparam int PW   = w3cf_pkg::PIX_W;
   localparam int CH   = w3cf_pkg::CHAN_W;

   // configuration registers
   logic [w3cf_pkg::FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [w3cf_pkg::FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [w3cf_pkg::MODE_W-1:0]         filter_mode_ff;
   logic [w3cf_pkg::GAIN_W-1:0]         boost_gain_ff;

   // raster position of the next pixel
   logic [CW-1:0] col_count_ff, col_count_in;
   logic [RW-1:0] row_count_ff, row_count_in;

   // compute stage
   logic          s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_pix_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic          s1_border_ff;
   logic          s1_interior_ff;

   // columns col-1 (0..2) and col-2 (3..5), rows top, mid, bottom
   logic [PW-1:0] win_ff [6];

   // output register and second slot for the pass-through after an interior result
   w3cf_pkg::result_type a_ff, a_in, b_ff, b_in;
   logic                 a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;

   logic [WCW-1:0] width_eff;
   logic [HCW-1:0] height_eff;
   logic           last_col, last_row;
   logic           req_accept, rsp_accept, out_free, s1_adv;
   logic [PW-1:0]  top_data, mid_data, filt;
   w3cf_pkg::result_type int_res, bord_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= w3cf_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= w3cf_pkg::FRAME_HEIGHT_RST;
         filter_mode_ff  <= w3cf_pkg::MODE_LAPLACIAN;
         boost_gain_ff   <= w3cf_pkg::BOOST_GAIN_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            w3cf_pkg::REG_FRAME_WIDTH:
               frame_width_ff  <= csr_data[w3cf_pkg::FRAME_WIDTH_W-1:0];
            w3cf_pkg::REG_FRAME_HEIGHT:
               frame_height_ff <= csr_data[w3cf_pkg::FRAME_HEIGHT_W-1:0];
            w3cf_pkg::REG_FILTER_MODE:
               filter_mode_ff  <= csr_data[w3cf_pkg::MODE_W-1:0];
            w3cf_pkg::REG_BOOST_GAIN:
               boost_gain_ff   <= csr_data[w3cf_pkg::GAIN_W-1:0];
         endcase
      end
   end

   // clamp the frame size to 3..MAX
   always_comb begin
      priority if (WCW'(frame_width_ff) < WCW'(3)) begin
         width_eff = WCW'(3);
      end else if (WCW'(frame_width_ff) > WCW'(MAX_WIDTH)) begin
         width_eff = WCW'(MAX_WIDTH);
      end else begin
         width_eff = WCW'(frame_width_ff);
      end
      priority if (HCW'(frame_height_ff) < HCW'(3)) begin
         height_eff = HCW'(3);
      end else if (HCW'(frame_height_ff) > HCW'(MAX_HEIGHT)) begin
         height_eff = HCW'(MAX_HEIGHT);
      end else begin
         height_eff = HCW'(frame_height_ff);
      end
   end

   assign last_col = WCW'(col_count_ff) >= (width_eff - WCW'(1));
   assign last_row = HCW'(row_count_ff) >= (height_eff - HCW'(1));

   // handshake: the compute stage moves on once both output slots will be free
   assign out_free   = !a_valid_ff || (rsp_tready && !b_valid_ff);
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = a_valid_ff && rsp_tready;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (req_accept) begin
         if (last_col) begin
            col_count_in = '0;
            row_count_in = last_row ? '0 : RW'(row_count_ff + RW'(1));
         end else begin
            col_count_in = CW'(col_count_ff + CW'(1));
         end
      end
      s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   // line buffers: read at acceptance, write back when the pixel leaves the compute stage
   w3cf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_one_up (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (req_accept),
      .rd_addr (col_count_ff),
      .rd_data (mid_data)
   );

   w3cf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_two_up (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (mid_data),
      .rd_en   (req_accept),
      .rd_addr (col_count_ff),
      .rd_data (top_data)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         filt[k*CH +: CH] = w3cf_pkg::filter_channel(
            filter_mode_ff, boost_gain_ff,
            win_ff[3][k*CH +: CH], win_ff[0][k*CH +: CH], top_data[k*CH +: CH],
            win_ff[4][k*CH +: CH], win_ff[1][k*CH +: CH], mid_data[k*CH +: CH],
            win_ff[5][k*CH +: CH], win_ff[2][k*CH +: CH], s1_pix_ff[k*CH +: CH]);
      end
   end

   always_comb begin
      int_res.rgb   = filt;
      int_res.col   = w3cf_pkg::OUT_COL_W'(CW'(s1_col_ff - CW'(1)));
      int_res.row   = w3cf_pkg::OUT_ROW_W'(RW'(s1_row_ff - RW'(1)));
      int_res.last  = !s1_border_ff;
      bord_res.rgb  = s1_pix_ff;
      bord_res.col  = w3cf_pkg::OUT_COL_W'(s1_col_ff);
      bord_res.row  = w3cf_pkg::OUT_ROW_W'(s1_row_ff);
      bord_res.last = 1'b1;
   end

   always_comb begin
      a_in       = a_ff;
      b_in       = b_ff;
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      if (rsp_accept) begin
         a_in       = b_ff;
         a_valid_in = b_valid_ff;
         b_valid_in = 1'b0;
      end
      if (s1_adv) begin
         if (s1_interior_ff) begin
            a_in       = int_res;
            a_valid_in = 1'b1;
            b_in       = bord_res;
            b_valid_in = s1_border_ff;
         end else begin
            a_in       = bord_res;
            a_valid_in = s1_border_ff;
            b_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         s1_valid_ff  <= s1_valid_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         if (s1_adv) begin
            // shift the window one column left
            win_ff[3] <= win_ff[0];
            win_ff[4] <= win_ff[1];
            win_ff[5] <= win_ff[2];
            win_ff[0] <= top_data;
            win_ff[1] <= mid_data;
            win_ff[2] <= s1_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff      <= req_tdata[PW-1:0];
         s1_col_ff      <= col_count_ff;
         s1_row_ff      <= row_count_ff;
         s1_border_ff   <= (col_count_ff == '0) || (row_count_ff == '0) || last_col || last_row;
         s1_interior_ff <= (col_count_ff >= CW'(2)) && (row_count_ff >= RW'(2));
      end
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign rsp_tvalid = a_valid_ff;
   assign rsp_tlast  = a_ff.last;
   assign rsp_tdata  = {{w3cf_pkg::RSP_PAD_W{1'b0}}, a_ff.rgb, a_ff.row, a_ff.col};

endmodule

// ----- rtl/w3cf_checker.sv -----
// Port checker for the 3x3 filter top level, attached by the bind below.
// Depends on w3cf_pkg for the result field layout.
module w3cf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic                             rsp_tlast,
   input logic [w3cf_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CLW = w3cf_pkg::OUT_COL_W;
   localparam int RLW = w3cf_pkg::OUT_ROW_W;

   logic                 rsp_accept;
   logic [CLW-1:0]       rsp_col;
   logic [RLW-1:0]       rsp_row;

   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign rsp_col    = rsp_tdata[CLW-1:0];
   assign rsp_row    = rsp_tdata[CLW +: RLW];

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction dropped or changed while stalled");

   // an interior result not marked last is followed at once by its border pass-through
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !rsp_tlast |=> rsp_tvalid)
      else $error("second result of a pixel not presented");

   a_second_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !rsp_tlast |=>
         rsp_col == CLW'($past(rsp_col) + CLW'(1)) &&
         rsp_row == RLW'($past(rsp_row) + RLW'(1)))
      else $error("border result not below and right of the interior result");

   a_second_last: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !rsp_tlast |=> rsp_tlast)
      else $error("more than two results for one pixel");

endmodule

bind window3x3_convolution_filter_top w3cf_checker u_w3cf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/window3x3_convolution_filter_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the 3x3 window RGB filter: streams frames in raster order,
// predicts every pass-through and filtered pixel, and checks each result transaction.
// Depends on w3cf_pkg and window3x3_convolution_filter_top.
module window3x3_convolution_filter_top_test;

   localparam int CHAN_W         = w3cf_pkg::CHAN_W;
   localparam int PIX_W          = w3cf_pkg::PIX_W;
   localparam int OUT_COL_W      = w3cf_pkg::OUT_COL_W;
   localparam int OUT_ROW_W      = w3cf_pkg::OUT_ROW_W;
   localparam int REQ_TDATA_W    = w3cf_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W    = w3cf_pkg::RSP_TDATA_W;
   localparam int RSP_PAD_W      = w3cf_pkg::RSP_PAD_W;
   localparam int FRAME_WIDTH_W  = w3cf_pkg::FRAME_WIDTH_W;
   localparam int FRAME_HEIGHT_W = w3cf_pkg::FRAME_HEIGHT_W;
   localparam int MODE_W         = w3cf_pkg::MODE_W;
   localparam int GAIN_W         = w3cf_pkg::GAIN_W;
   localparam int CSR_INDEX_W    = w3cf_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W     = w3cf_pkg::CSR_DATA_W;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 4096;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_WIDTH    = 40;
   localparam int RANDOM_ITEMS  = 520;
   localparam int QUIET_ITEMS   = 150;
   localparam int LIMIT_CYCLES  = 1000000;

   // index 0 red, 1 green, 2 blue; same packing as req_tdata
   typedef logic [2:0][CHAN_W-1:0] rgb_type;

   typedef struct packed {
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
      rgb_type              color;
      logic                 last;
   } out_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // predicted block state
   logic [FRAME_WIDTH_W-1:0]  frame_w_reg;
   logic [FRAME_HEIGHT_W-1:0] frame_h_reg;
   logic [MODE_W-1:0]         mode_reg;
   logic [GAIN_W-1:0]         gain_reg;
   rgb_type                   prev_row [0:MAX_W-1];
   rgb_type                   prev_prev_row [0:MAX_W-1];
   rgb_type                   window_cols [0:5];
   int                        col_count;
   int                        row_count;

   rgb_type       pixels_to_send [$];
   out_pixel_type pending_results [$];
   int         pixels_queued   = 0;
   int         pixels_accepted = 0;
   int         mismatches      = 0;
   int         cycle_count     = 0;
   logic       req_taken       = 1'b0;
   int         req_gap         = 0;
   int         rsp_hold        = 0;
   logic       quiet_tail      = 1'b0;
   logic       long_hold_armed = 1'b0;
   logic       long_hold_done  = 1'b0;

   window3x3_convolution_filter_top #(
      .MAX_WIDTH (MAX_W),
      .MAX_HEIGHT(MAX_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int span_of(input int value, input int hi);
      if (value < 3) begin
         return 3;
      end
      return (value > hi) ? hi : value;
   endfunction

   function automatic logic [CHAN_W-1:0] clip_byte(input int v);
      if (v < 0) begin
         return '0;
      end
      return (v > 255) ? 8'd255 : 8'(v);
   endfunction

   // win index is row*3 + col, row 0 on top, col 0 on the left
   function automatic logic [CHAN_W-1:0] filter_pixel(input logic [MODE_W-1:0] mode,
                                                      input logic [GAIN_W-1:0] gain,
                                                      input logic [8:0][CHAN_W-1:0] win);
      int c, g, edges, corners, gx, gy, s;
      c       = win[4];
      g       = gain;
      edges   = win[1] + win[3] + win[5] + win[7];
      corners = win[0] + win[2] + win[6] + win[8];
      gx      = (win[2] + 2 * win[5] + win[8]) - (win[0] + 2 * win[3] + win[6]);
      gy      = (win[6] + 2 * win[7] + win[8]) - (win[0] + 2 * win[1] + win[2]);
      case (mode)
         w3cf_pkg::MODE_LAPLACIAN: begin
            return clip_byte(9 * c - edges - corners);
         end
         w3cf_pkg::MODE_BOOST: begin
            s = 16 * (8 * c - edges - corners) + g * c;
            return (s < 0) ? 8'd0 : clip_byte(s / 16);
         end
         w3cf_pkg::MODE_SOBEL: begin
            s = int'(clip_byte(gx)) + int'(clip_byte(gy));
            return clip_byte(s);
         end
         default: begin
            return clip_byte((corners + 2 * edges + 4 * c) / 16);
         end
      endcase
   endfunction

   // Shift one pixel into the window and queue the results it completes.
   task automatic advance_window(input rgb_type bot);
      int                     w, h, col, row, k;
      rgb_type                mid, top;
      logic [8:0][CHAN_W-1:0] win;
      logic                   last_col, last_row, border;
      out_pixel_type          res;
      w   = span_of(frame_w_reg, MAX_W);
      h   = span_of(frame_h_reg, MAX_H);
      col = col_count;
      row = row_count;
      mid = prev_row[col];
      top = prev_prev_row[col];
      prev_prev_row[col] = mid;
      prev_row[col]      = bot;
      last_col = col >= w - 1;
      last_row = row >= h - 1;
      border   = col == 0 || row == 0 || last_col || last_row;
      // interior result first, then the pass-through of the arriving pixel
      if (col >= 2 && row >= 2) begin
         res.col  = OUT_COL_W'(col - 1);
         res.row  = OUT_ROW_W'(row - 1);
         res.last = !border;
         for (k = 0; k < 3; k++) begin
            win[0] = window_cols[3][k];
            win[3] = window_cols[4][k];
            win[6] = window_cols[5][k];
            win[1] = window_cols[0][k];
            win[4] = window_cols[1][k];
            win[7] = window_cols[2][k];
            win[2] = top[k];
            win[5] = mid[k];
            win[8] = bot[k];
            res.color[k] = filter_pixel(mode_reg, gain_reg, win);
         end
         pending_results.push_back(res);
      end
      if (border) begin
         res.col   = OUT_COL_W'(col);
         res.row   = OUT_ROW_W'(row);
         res.color = bot;
         res.last  = 1'b1;
         pending_results.push_back(res);
      end
      window_cols[3] = window_cols[0];
      window_cols[4] = window_cols[1];
      window_cols[5] = window_cols[2];
      window_cols[0] = top;
      window_cols[1] = mid;
      window_cols[2] = bot;
      if (last_col) begin
         col_count = 0;
         row_count = last_row ? 0 : row + 1;
      end else begin
         col_count = col + 1;
      end
   endtask

   task automatic note_mismatch(input string field, input out_pixel_type want,
                                input logic [31:0] exp_v, input logic [31:0] act_v);
      mismatches++;
      $display("%0t: %s of pixel (%0d,%0d): expected %0d, got %0d",
               $time, field, want.col, want.row, exp_v, act_v);
   endtask

   // Monitor: track config and accepted pixels, then check the result transaction.
   always @(posedge clock) begin : stream_monitor
      out_pixel_type         got, want;
      logic [RSP_PAD_W-1:0]  pad;
      int                    k;
      if (reset) begin
         frame_w_reg = w3cf_pkg::FRAME_WIDTH_RST;
         frame_h_reg = w3cf_pkg::FRAME_HEIGHT_RST;
         mode_reg    = w3cf_pkg::MODE_LAPLACIAN;
         gain_reg    = w3cf_pkg::BOOST_GAIN_RST;
         for (k = 0; k < MAX_W; k++) begin
            prev_row[k]      = '0;
            prev_prev_row[k] = '0;
         end
         for (k = 0; k < 6; k++) begin
            window_cols[k] = '0;
         end
         col_count = 0;
         row_count = 0;
         req_taken = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               w3cf_pkg::REG_FRAME_WIDTH:  frame_w_reg = csr_data[FRAME_WIDTH_W-1:0];
               w3cf_pkg::REG_FRAME_HEIGHT: frame_h_reg = csr_data[FRAME_HEIGHT_W-1:0];
               w3cf_pkg::REG_FILTER_MODE:  mode_reg    = csr_data[MODE_W-1:0];
               w3cf_pkg::REG_BOOST_GAIN:   gain_reg    = csr_data[GAIN_W-1:0];
               default: ;
            endcase
         end
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            advance_window(req_tdata);
            pixels_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.col   = rsp_tdata[OUT_COL_W-1:0];
            got.row   = rsp_tdata[OUT_COL_W +: OUT_ROW_W];
            got.color = rsp_tdata[OUT_COL_W + OUT_ROW_W +: PIX_W];
            got.last  = rsp_tlast;
            pad       = rsp_tdata[RSP_TDATA_W-1 -: RSP_PAD_W];
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: result transaction: expected none, got pixel (%0d,%0d) %h",
                        $time, got.col, got.row, got.color);
            end else begin
               want = pending_results.pop_front();
               if (got.col !== want.col) note_mismatch("out_col", want, want.col, got.col);
               if (got.row !== want.row) note_mismatch("out_row", want, want.row, got.row);
               if (got.color[0] !== want.color[0]) begin
                  note_mismatch("out_red", want, want.color[0], got.color[0]);
               end
               if (got.color[1] !== want.color[1]) begin
                  note_mismatch("out_green", want, want.color[1], got.color[1]);
               end
               if (got.color[2] !== want.color[2]) begin
                  note_mismatch("out_blue", want, want.color[2], got.color[2]);
               end
               if (got.last !== want.last) note_mismatch("rsp_tlast", want, want.last, got.last);
               if (pad !== '0) note_mismatch("tdata padding", want, 0, pad);
            end
         end
      end
   end

   // Driver: offer queued pixels, with random gaps outside the quiet tail.
   always @(negedge clock) begin : pixel_driver
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap != 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 3);
            req_tvalid <= 1'b0;
         end else if (pixels_to_send.size() != 0) begin
            req_tdata  <= pixels_to_send.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result-side backpressure: short random stalls plus one long hold.
   always @(negedge clock) begin : result_ready_driver
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (long_hold_armed && !long_hold_done) begin
         long_hold_done = 1'b1;
         rsp_hold = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("window3x3_convolution_filter_top_test NOT OK");
         $finish;
      end
   end

   task automatic queue_pixel(input rgb_type px);
      pixels_to_send.push_back(px);
      pixels_queued++;
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pixels_accepted != pixels_queued || pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = CSR_DATA_W'(value);
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_filter(input logic [MODE_W-1:0] mode, input int gain);
      write_reg(w3cf_pkg::REG_FILTER_MODE, mode);
      write_reg(w3cf_pkg::REG_BOOST_GAIN, gain);
   endtask

   function automatic int random_gain();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] random_mode();
      return MODE_W'(w3cf_pkg::MODE_LAPLACIAN + $urandom_range(0, 3));
   endfunction

   // each channel is base plus noise of the given spread, clipped to a byte
   function automatic rgb_type random_pixel(input rgb_type base, input int spread);
      rgb_type px;
      int      k;
      for (k = 0; k < 3; k++) begin
         px[k] = clip_byte(int'(base[k]) + int'($urandom_range(0, spread)) - spread / 2);
      end
      return px;
   endfunction

   // bright center column in red, dark in green, ramp in blue; flip inverts all
   function automatic rgb_type pattern_pixel(input int col, input int row, input logic flip);
      rgb_type px;
      px[0] = (col == 1) ? 8'd255 : 8'd0;
      px[1] = ~px[0];
      px[2] = 8'(col * 100 + row * 17);
      return flip ? ~px : px;
   endfunction

   initial begin : stimulus
      int      k, f, frames, n, split, w_val, h_val, spread, random_sent;
      rgb_type base;
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // 3x4 frames: one interior result before and one after a mid-frame mode change
      write_reg(w3cf_pkg::REG_FRAME_WIDTH, 3);
      write_reg(w3cf_pkg::REG_FRAME_HEIGHT, 4);
      write_reg(w3cf_pkg::REG_FILTER_MODE, w3cf_pkg::MODE_LAPLACIAN);
      for (k = 0; k < 9; k++) queue_pixel(pattern_pixel(k % 3, k / 3, 1'b0));
      wait_drained();
      write_reg(w3cf_pkg::REG_FILTER_MODE, w3cf_pkg::MODE_SOBEL);
      for (k = 9; k < 12; k++) queue_pixel(pattern_pixel(k % 3, k / 3, 1'b0));
      wait_drained();
      write_filter(w3cf_pkg::MODE_BOOST, 255);
      for (k = 0; k < 9; k++) queue_pixel(pattern_pixel(k % 3, k / 3, 1'b1));
      wait_drained();
      write_filter(w3cf_pkg::MODE_GAUSSIAN, 0);
      for (k = 9; k < 12; k++) queue_pixel(pattern_pixel(k % 3, k / 3, 1'b1));

      // narrow the row while the column counter sits past the new last column
      wait_drained();
      write_reg(w3cf_pkg::REG_FRAME_WIDTH, 6);
      write_reg(w3cf_pkg::REG_FRAME_HEIGHT, 3);
      base = {3{8'd128}};
      for (k = 0; k < 4; k++) queue_pixel(random_pixel(base, 255));
      wait_drained();
      write_reg(w3cf_pkg::REG_FRAME_WIDTH, 3);
      for (k = 0; k < 7; k++) queue_pixel(random_pixel(base, 255));

      // shorten the frame while the row counter sits past the new last row
      wait_drained();
      write_reg(w3cf_pkg::REG_FRAME_WIDTH, 0);
      write_reg(w3cf_pkg::REG_FRAME_HEIGHT, 8191);
      for (k = 0; k < 12; k++) queue_pixel(random_pixel(base, 255));
      wait_drained();
      write_reg(w3cf_pkg::REG_FRAME_HEIGHT, 3);
      for (k = 0; k < 3; k++) queue_pixel(random_pixel(base, 255));

      // one full frame held off on the result side long enough to stall the input
      wait_drained();
      write_reg(w3cf_pkg::REG_FRAME_WIDTH, HOLD_WIDTH);
      write_reg(w3cf_pkg::REG_FRAME_HEIGHT, 0);
      write_filter(random_mode(), random_gain());
      long_hold_armed = 1'b1;
      base = {3{8'd128}};
      for (k = 0; k < 3 * HOLD_WIDTH; k++) queue_pixel(random_pixel(base, 40));

      // random frames, mostly small, sometimes with out-of-range sizes
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
         w_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
         h_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
         wait_drained();
         write_reg(w3cf_pkg::REG_FRAME_WIDTH, w_val);
         write_reg(w3cf_pkg::REG_FRAME_HEIGHT, h_val);
         write_filter(random_mode(), random_gain());
         n = span_of(w_val, MAX_W) * span_of(h_val, MAX_H);
         frames = $urandom_range(1, 2);
         for (f = 0; f < frames; f++) begin
            base = rgb_type'($urandom());
            case ($urandom_range(0, 2))
               0: spread = 8;
               1: spread = 40;
               default: spread = 255;
            endcase
            split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : 0;
            for (k = 0; k < n; k++) begin
               if (split != 0 && k == split) begin
                  // switch the filter mid-frame while the block is idle
                  wait_drained();
                  write_filter(random_mode(), random_gain());
               end
               queue_pixel(random_pixel(base, spread));
            end
            random_sent += n;
         end
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("window3x3_convolution_filter_top_test OK");
      end else begin
         $display("window3x3_convolution_filter_top_test NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/w3cf_pkg.sv
rtl/w3cf_ram.sv
rtl/window3x3_convolution_filter_top.sv
rtl/w3cf_checker.sv
sim/window3x3_convolution_filter_top_test.sv
